[hw/rtl/rama_pkg.sv]
// Package for the rational add/multiply/reduce block.
// Shared constants, result widths and the back-end sequencer types.
// No dependencies.
package rama_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam int SUM_NUM_W  = 33;
  localparam int SUM_DEN_W  = 31;
  localparam int PROD_NUM_W = 32;
  localparam int PROD_DEN_W = 31;

  // Scratch width for sign encoding ahead of truncation to a port width.
  localparam int WIDE_W = 64;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_ADD,
    B_GCD_GO,
    B_GCD_WAIT,
    B_DIV_GO,
    B_DIV_WAIT,
    B_OUT
  } back_state_t;

  typedef enum logic [1:0] {
    MUL_TA,
    MUL_TB,
    MUL_DEN,
    MUL_PN
  } mul_sel_t;

  // Control from the back-end sequencer to the queue, its shared units and the result register.
  typedef struct packed {
    logic q_pop;
    logic gcd_go;
    logic div_go;
    logic out_load;
  } back_ctl_t;

endpackage

[hw/rtl/rama_front.sv]
// Front end: takes an input beat, splits fields into sign and magnitude
// and flags a zero denominator. Feeds the item queue. Uses rama_pkg.
module rama_front #(
  parameter int W  = rama_pkg::OPERAND_WIDTH_DEF,
  parameter int QW = 4 * rama_pkg::OPERAND_WIDTH_DEF + 5
) (
  input  logic          in_push,
  output logic          in_full,
  input  logic [W-1:0]  n1,
  input  logic [W-1:0]  d1,
  input  logic [W-1:0]  n2,
  input  logic [W-1:0]  d2,
  input  logic          q_full,
  output logic          q_push,
  output logic [QW-1:0] q_data
);
  import rama_pkg::*;

  logic         sn1, sd1, sn2, sd2, undef;
  logic [W-1:0] n1m, d1m, n2m, d2m;

  always_comb begin
    sn1 = n1[W-1];
    sd1 = d1[W-1];
    sn2 = n2[W-1];
    sd2 = d2[W-1];
    n1m = sn1 ? W'(-n1) : n1;
    d1m = sd1 ? W'(-d1) : d1;
    n2m = sn2 ? W'(-n2) : n2;
    d2m = sd2 ? W'(-d2) : d2;
    undef = (d1m == '0) || (d2m == '0);
  end

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;
  assign q_data  = {undef, sn1, sd1, sn2, sd2, n1m, d1m, n2m, d2m};

endmodule

[hw/rtl/rama_queue.sv]
// Short item queue between front end and back end, flop based.
// Uses rama_pkg for the default depth.
module rama_queue #(
  parameter int QW    = 4 * rama_pkg::OPERAND_WIDTH_DEF + 5,
  parameter int DEPTH = rama_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [QW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output logic [QW-1:0] rdata
);
  import rama_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [QW-1:0] mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/rama_gcd.sv]
// Binary GCD unit, one step per cycle, for two nonzero operands.
// Uses rama_pkg.
module rama_gcd #(
  parameter int GW = 2 * rama_pkg::OPERAND_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [GW-1:0] a_in,
  input  logic [GW-1:0] b_in,
  output logic          busy,
  output logic [GW-1:0] g
);
  import rama_pkg::*;

  localparam int KW = $clog2(GW);

  logic [GW-1:0] a_r, b_r, g_r;
  logic [KW-1:0] k_r;
  logic          busy_r;

  assign busy = busy_r;
  assign g    = g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (go) begin
      busy_r <= 1'b1;
    end else if (busy_r && (a_r == b_r)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      a_r <= a_in;
      b_r <= b_in;
      k_r <= '0;
    end else if (busy_r) begin
      priority if (a_r == b_r) begin
        g_r <= a_r << k_r;
      end else if (!a_r[0] && !b_r[0]) begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        k_r <= k_r + 1'b1;
      end else if (!a_r[0]) begin
        a_r <= a_r >> 1;
      end else if (!b_r[0]) begin
        b_r <= b_r >> 1;
      end else if (a_r > b_r) begin
        a_r <= a_r - b_r;
      end else begin
        b_r <= b_r - a_r;
      end
    end
  end

endmodule

[hw/rtl/rama_div.sv]
// Restoring divider, one quotient bit per cycle.
// Uses rama_pkg.
module rama_div #(
  parameter int GW = 2 * rama_pkg::OPERAND_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [GW-1:0] dividend,
  input  logic [GW-1:0] divisor,
  output logic          busy,
  output logic [GW-1:0] quotient
);
  import rama_pkg::*;

  localparam int CW = $clog2(GW + 1);

  logic [GW-1:0] quo_r, rem_r, dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [GW:0]   rem_sh, rem_sub;
  logic          fits;

  assign busy     = busy_r;
  assign quotient = quo_r;

  always_comb begin
    rem_sh  = {rem_r, quo_r[GW-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    fits    = (rem_sh >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (go) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(GW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[GW-2:0], fits};
      rem_r <= fits ? rem_sub[GW-1:0] : rem_sh[GW-1:0];
    end
  end

endmodule

[hw/rtl/rama_back.sv]
// Back end: multiplies, forms the sum, reduces sum and product through
// shared GCD and divider units, holds the result register. Uses rama_pkg.
module rama_back #(
  parameter int W  = rama_pkg::OPERAND_WIDTH_DEF,
  parameter int QW = 4 * rama_pkg::OPERAND_WIDTH_DEF + 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty,
  input  logic [QW-1:0]                      q_data,
  output logic                               q_pop,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic signed [rama_pkg::SUM_NUM_W-1:0]  sum_num,
  output logic        [rama_pkg::SUM_DEN_W-1:0]  sum_den,
  output logic signed [rama_pkg::PROD_NUM_W-1:0] prod_num,
  output logic        [rama_pkg::PROD_DEN_W-1:0] prod_den,
  output logic                               undef
);
  import rama_pkg::*;

  localparam int GW = 2 * W;

  back_state_t   st_r, st_nxt;
  back_ctl_t     ctl;
  mul_sel_t      sel_r;

  logic [W-1:0]  n1_r, d1_r, n2_r, d2_r;
  logic          sn1_r, sd1_r, sn2_r, sd2_r, undef_r;
  logic [GW-1:0] ta_r, tb_r, den_r, pn_r, snum_r;
  logic          ssign_r, psign_r, phase_r;
  logic [GW-1:0] srn_r, srd_r, prn_r, prd_r;
  logic          srs_r, prs_r;

  logic          out_valid_r;
  logic signed [SUM_NUM_W-1:0]  sum_num_r;
  logic        [SUM_DEN_W-1:0]  sum_den_r;
  logic signed [PROD_NUM_W-1:0] prod_num_r;
  logic        [PROD_DEN_W-1:0] prod_den_r;
  logic                         undef_out_r;

  logic [W-1:0]  mul_a, mul_b;
  logic [GW-1:0] mul_res;
  logic [GW-1:0] cur_num;
  logic          cur_sign;
  logic          sa, sb, dsign;
  logic [GW-1:0] gcd_g, qn, qd;
  logic          gcd_busy, div_busy_n, div_busy_d;
  logic [WIDE_W-1:0] sn_wide, pn_wide;

  // Queue item fields.
  logic          qi_undef, qi_sn1, qi_sd1, qi_sn2, qi_sd2;
  logic [W-1:0]  qi_n1, qi_d1, qi_n2, qi_d2;

  assign {qi_undef, qi_sn1, qi_sd1, qi_sn2, qi_sd2, qi_n1, qi_d1, qi_n2, qi_d2} = q_data;

  assign cur_num  = phase_r ? pn_r : snum_r;
  assign cur_sign = phase_r ? psign_r : ssign_r;
  assign dsign    = sd1_r ^ sd2_r;
  assign sa       = (sn1_r ^ sd2_r) && (ta_r != '0);
  assign sb       = (sn2_r ^ sd1_r) && (tb_r != '0);

  always_comb begin
    unique case (sel_r)
      MUL_TA: begin
        mul_a = n1_r;
        mul_b = d2_r;
      end
      MUL_TB: begin
        mul_a = n2_r;
        mul_b = d1_r;
      end
      MUL_DEN: begin
        mul_a = d1_r;
        mul_b = d2_r;
      end
      MUL_PN: begin
        mul_a = n1_r;
        mul_b = n2_r;
      end
      default: begin
        mul_a = n1_r;
        mul_b = d2_r;
      end
    endcase
    mul_res = mul_a * mul_b;
  end

  rama_gcd #(.GW(GW)) u_gcd (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (ctl.gcd_go),
    .a_in (cur_num),
    .b_in (den_r),
    .busy (gcd_busy),
    .g    (gcd_g)
  );

  rama_div #(.GW(GW)) u_div_num (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (ctl.div_go),
    .dividend(cur_num),
    .divisor (gcd_g),
    .busy    (div_busy_n),
    .quotient(qn)
  );

  rama_div #(.GW(GW)) u_div_den (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (ctl.div_go),
    .dividend(den_r),
    .divisor (gcd_g),
    .busy    (div_busy_d),
    .quotient(qd)
  );

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          st_nxt = qi_undef ? B_OUT : B_MUL;
        end
      end
      B_MUL: begin
        if (sel_r == MUL_PN) begin
          st_nxt = B_ADD;
        end
      end
      B_ADD: begin
        st_nxt = B_GCD_GO;
      end
      B_GCD_GO: begin
        if (cur_num != '0) begin
          st_nxt = B_GCD_WAIT;
        end else if (phase_r) begin
          st_nxt = B_OUT;
        end
      end
      B_GCD_WAIT: begin
        if (!gcd_busy) begin
          st_nxt = B_DIV_GO;
        end
      end
      B_DIV_GO: begin
        st_nxt = B_DIV_WAIT;
      end
      B_DIV_WAIT: begin
        if (!div_busy_n && !div_busy_d) begin
          st_nxt = phase_r ? B_OUT : B_GCD_GO;
        end
      end
      B_OUT: begin
        if (!out_valid_r || out_pop) begin
          st_nxt = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    ctl = '0;
    unique case (st_r)
      B_IDLE:   ctl.q_pop    = !q_empty;
      B_GCD_GO: ctl.gcd_go   = (cur_num != '0);
      B_DIV_GO: ctl.div_go   = 1'b1;
      B_OUT:    ctl.out_load = !out_valid_r || out_pop;
      default:  ctl = '0;
    endcase
  end

  assign q_pop = ctl.q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    unique case (st_r)
      B_IDLE: begin
        n1_r    <= qi_n1;
        d1_r    <= qi_d1;
        n2_r    <= qi_n2;
        d2_r    <= qi_d2;
        sn1_r   <= qi_sn1;
        sd1_r   <= qi_sd1;
        sn2_r   <= qi_sn2;
        sd2_r   <= qi_sd2;
        undef_r <= qi_undef;
        sel_r   <= MUL_TA;
        phase_r <= 1'b0;
        srn_r   <= '0;
        srd_r   <= '0;
        prn_r   <= '0;
        prd_r   <= '0;
        srs_r   <= 1'b0;
        prs_r   <= 1'b0;
      end
      B_MUL: begin
        unique case (sel_r)
          MUL_TA:  ta_r  <= mul_res;
          MUL_TB:  tb_r  <= mul_res;
          MUL_DEN: den_r <= mul_res;
          MUL_PN:  pn_r  <= mul_res;
          default: ta_r  <= mul_res;
        endcase
        sel_r <= mul_sel_t'(sel_r + 2'd1);
      end
      B_ADD: begin
        priority if (sa == sb) begin
          snum_r  <= ta_r + tb_r;
          ssign_r <= sa ^ dsign;
        end else if (ta_r >= tb_r) begin
          snum_r  <= ta_r - tb_r;
          ssign_r <= sa ^ dsign;
        end else begin
          snum_r  <= tb_r - ta_r;
          ssign_r <= sb ^ dsign;
        end
        psign_r <= sn1_r ^ sn2_r ^ dsign;
      end
      B_GCD_GO: begin
        if (cur_num == '0) begin
          if (phase_r) begin
            prn_r <= '0;
            prd_r <= GW'(1);
            prs_r <= 1'b0;
          end else begin
            srn_r <= '0;
            srd_r <= GW'(1);
            srs_r <= 1'b0;
          end
          phase_r <= 1'b1;
        end
      end
      B_DIV_WAIT: begin
        if (!div_busy_n && !div_busy_d) begin
          if (phase_r) begin
            prn_r <= qn;
            prd_r <= qd;
            prs_r <= cur_sign;
          end else begin
            srn_r <= qn;
            srd_r <= qd;
            srs_r <= cur_sign;
          end
          phase_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sn_wide = WIDE_W'(srn_r);
    pn_wide = WIDE_W'(prn_r);
    if (srs_r) begin
      sn_wide = -sn_wide;
    end
    if (prs_r) begin
      pn_wide = -pn_wide;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      sum_num_r   <= sn_wide[SUM_NUM_W-1:0];
      sum_den_r   <= SUM_DEN_W'(srd_r);
      prod_num_r  <= pn_wide[PROD_NUM_W-1:0];
      prod_den_r  <= PROD_DEN_W'(prd_r);
      undef_out_r <= undef_r;
    end
  end

  assign out_empty = !out_valid_r;
  assign sum_num   = sum_num_r;
  assign sum_den   = sum_den_r;
  assign prod_num  = prod_num_r;
  assign prod_den  = prod_den_r;
  assign undef     = undef_out_r;

endmodule

[hw/rtl/rational_add_mul_reduce.sv]
// Rational add and multiply with reduction to lowest terms. Top level.
// Instantiates rama_front, rama_queue and rama_back; uses rama_pkg.
//
// Takes two signed fractions n1/d1 and n2/d2 per input beat and returns
// one result beat with the reduced sum and product; denominators are
// positive, a zero numerator reads 0/1, and a zero input denominator sets
// undefined with all four result fields 0. Input items are buffered in a
// queue of QUEUE_DEPTH entries, so the input side keeps accepting while a
// result waits to be popped, until that queue fills. Items are processed
// one at a time: the back end takes the item, multiplies n1*d2, n2*d1,
// d1*d2 and n1*n2 in turn, forms the sum, reduces the sum and then the
// product, each through a binary GCD (one halving or one subtraction per
// cycle) followed by a bit-serial divide, and loads the result register.
// An undefined item goes straight to the result register, and a zero sum
// or product numerator skips its GCD and divide; an unpopped result holds
// the back end. The single GCD unit and the bit-serial dividers are shared
// between sum and product.
module rational_add_mul_reduce #(
  parameter int OPERAND_WIDTH = rama_pkg::OPERAND_WIDTH_DEF,
  parameter int QUEUE_DEPTH   = rama_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_push,
  output logic                                       in_full,
  input  logic signed [OPERAND_WIDTH-1:0]            in_first_numerator,
  input  logic signed [OPERAND_WIDTH-1:0]            in_first_denominator,
  input  logic signed [OPERAND_WIDTH-1:0]            in_second_numerator,
  input  logic signed [OPERAND_WIDTH-1:0]            in_second_denominator,
  output logic                                       out_empty,
  input  logic                                       out_pop,
  output logic signed [rama_pkg::SUM_NUM_W-1:0]      out_sum_numerator,
  output logic        [rama_pkg::SUM_DEN_W-1:0]      out_sum_denominator,
  output logic signed [rama_pkg::PROD_NUM_W-1:0]     out_product_numerator,
  output logic        [rama_pkg::PROD_DEN_W-1:0]     out_product_denominator,
  output logic                                       out_undefined
);
  import rama_pkg::*;

  localparam int QW = 4 * OPERAND_WIDTH + 5;

  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  rama_front #(.W(OPERAND_WIDTH), .QW(QW)) u_front (
    .in_push(in_push),
    .in_full(in_full),
    .n1     (in_first_numerator),
    .d1     (in_first_denominator),
    .n2     (in_second_numerator),
    .d2     (in_second_denominator),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  rama_queue #(.QW(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .empty(q_empty),
    .rdata(q_rdata)
  );

  rama_back #(.W(OPERAND_WIDTH), .QW(QW)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .sum_num  (out_sum_numerator),
    .sum_den  (out_sum_denominator),
    .prod_num (out_product_numerator),
    .prod_den (out_product_denominator),
    .undef    (out_undefined)
  );

endmodule

[tb/sv/rational_add_mul_reduce_tb.sv]
// Testbench for rational_add_mul_reduce: drives fraction pairs through the queue ports
// and checks each result beat against a predicted reduced sum and product.
// Depends on rama_pkg and the rational_add_mul_reduce RTL.
module rational_add_mul_reduce_tb;
  import rama_pkg::*;

  localparam int OPW         = OPERAND_WIDTH_DEF;
  localparam int MOST_NEG    = -(1 << (OPW - 1));
  localparam int MOST_POS    = (1 << (OPW - 1)) - 1;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 400;

  typedef struct packed {
    logic signed [SUM_NUM_W-1:0]  sum_num;
    logic        [SUM_DEN_W-1:0]  sum_den;
    logic signed [PROD_NUM_W-1:0] prod_num;
    logic        [PROD_DEN_W-1:0] prod_den;
    logic                         undef;
  } fraction_pair_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_push;
  logic in_full;
  logic signed [OPW-1:0] in_first_numerator;
  logic signed [OPW-1:0] in_first_denominator;
  logic signed [OPW-1:0] in_second_numerator;
  logic signed [OPW-1:0] in_second_denominator;
  logic out_empty;
  logic out_pop;
  logic signed [SUM_NUM_W-1:0]  out_sum_numerator;
  logic        [SUM_DEN_W-1:0]  out_sum_denominator;
  logic signed [PROD_NUM_W-1:0] out_product_numerator;
  logic        [PROD_DEN_W-1:0] out_product_denominator;
  logic out_undefined;

  fraction_pair_t pending_results[$];
  int  mismatch_count = 0;
  bit  send_idle_on = 1'b1;
  bit  recv_idle_on = 1'b1;

  rational_add_mul_reduce uut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_push                 (in_push),
    .in_full                 (in_full),
    .in_first_numerator      (in_first_numerator),
    .in_first_denominator    (in_first_denominator),
    .in_second_numerator     (in_second_numerator),
    .in_second_denominator   (in_second_denominator),
    .out_empty               (out_empty),
    .out_pop                 (out_pop),
    .out_sum_numerator       (out_sum_numerator),
    .out_sum_denominator     (out_sum_denominator),
    .out_product_numerator   (out_product_numerator),
    .out_product_denominator (out_product_denominator),
    .out_undefined           (out_undefined)
  );

  always #4 clk = ~clk;

  // lowest terms, positive denominator, zero reads 0/1; den_in must be nonzero
  function automatic void reduce_fraction(input longint num_in, input longint den_in,
                                          output longint num_out, output longint den_out);
    longint a, b, t;
    if (num_in == 0) begin
      num_out = 0;
      den_out = 1;
      return;
    end
    if (den_in < 0) begin
      num_in = -num_in;
      den_in = -den_in;
    end
    a = (num_in < 0) ? -num_in : num_in;
    b = den_in;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    num_out = num_in / a;
    den_out = den_in / a;
  endfunction

  function automatic fraction_pair_t predict_sum_product(input logic signed [OPW-1:0] n1,
                                                         input logic signed [OPW-1:0] d1,
                                                         input logic signed [OPW-1:0] n2,
                                                         input logic signed [OPW-1:0] d2);
    fraction_pair_t r;
    longint sn, sd, pn, pd;
    r = '0;
    if (d1 == 0 || d2 == 0) begin
      r.undef = 1'b1;
      return r;
    end
    reduce_fraction(longint'(n1) * longint'(d2) + longint'(n2) * longint'(d1),
                    longint'(d1) * longint'(d2), sn, sd);
    reduce_fraction(longint'(n1) * longint'(n2), longint'(d1) * longint'(d2), pn, pd);
    r.sum_num  = sn[SUM_NUM_W-1:0];
    r.sum_den  = sd[SUM_DEN_W-1:0];
    r.prod_num = pn[PROD_NUM_W-1:0];
    r.prod_den = pd[PROD_DEN_W-1:0];
    return r;
  endfunction

  function automatic int draw_operand(input bit is_den);
    int pick;
    int v;
    pick = $urandom_range(0, 19);
    case (pick)
      0:       v = is_den ? 0 : $urandom_range(0, 1);
      1:       v = MOST_NEG;
      2:       v = MOST_POS;
      3, 4, 5, 6, 7, 8: v = int'($urandom_range(0, 24)) - 12;
      9, 10, 11, 12:    v = (int'($urandom_range(0, 12)) - 6) * int'($urandom_range(1, 360));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch %s: got %0d, want %0d", what, got_v, want_v);
  endtask

  // one input beat; returns at the edge that accepts it, push left high
  task automatic send_fractions(input int n1, input int d1, input int n2, input int d2);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_first_numerator    <= n1[OPW-1:0];
    in_first_denominator  <= d1[OPW-1:0];
    in_second_numerator   <= n2[OPW-1:0];
    in_second_denominator <= d2[OPW-1:0];
    in_push               <= 1'b1;
    do @(posedge clk); while (in_full);
    pending_results.push_back(predict_sum_product(n1[OPW-1:0], d1[OPW-1:0],
                                                  n2[OPW-1:0], d2[OPW-1:0]));
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_pair();
    send_fractions(draw_operand(1'b0), draw_operand(1'b1), draw_operand(1'b0),
                   draw_operand(1'b1));
  endtask

  task automatic test_extremes();
    send_fractions(MOST_POS, MOST_POS, MOST_POS, MOST_POS);
    send_fractions(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
    send_fractions(MOST_NEG, 1, MOST_NEG, 1);
    send_fractions(MOST_NEG, MOST_POS, MOST_POS, MOST_NEG);
    send_fractions(MOST_POS, MOST_NEG, MOST_NEG, MOST_POS);
    send_fractions(MOST_NEG, -1, MOST_NEG, -1);
    send_fractions(1, -1, 1, -1);
    send_fractions(1, 2, -1, 2);
    send_fractions(-1, -3, 2, 6);
    send_fractions(6, 4, 10, 15);
    send_fractions(MOST_POS, 1, 1, MOST_POS);
  endtask

  task automatic test_zero_denominator();
    send_fractions(5, 0, 3, 7);
    send_fractions(5, 7, 3, 0);
    send_fractions(0, 0, 0, 0);
    send_fractions(MOST_NEG, 0, MOST_POS, 0);
  endtask

  task automatic test_zero_numerator();
    send_fractions(0, 5, 0, -7);
    send_fractions(0, MOST_NEG, 9, 3);
    send_fractions(4, 9, 0, MOST_NEG);
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      repeat (5) send_random_pair();
      hold_until_drained();
    end
  endtask

  task automatic test_random_traffic();
    for (int blk = 0; blk < 20; blk++) begin
      send_idle_on = $urandom_range(0, 3) != 0;
      recv_idle_on = $urandom_range(0, 3) != 0;
      repeat (50) send_random_pair();
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  initial begin : result_checker
    fraction_pair_t got, want;
    int pop_wait;
    out_pop  = 1'b0;
    pop_wait = 0;
    forever begin
      @(negedge clk);
      out_pop <= (pop_wait == 0);
      if (pop_wait != 0) pop_wait--;
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        got.sum_num  = out_sum_numerator;
        got.sum_den  = out_sum_denominator;
        got.prod_num = out_product_numerator;
        got.prod_den = out_product_denominator;
        got.undef    = out_undefined;
        if (pending_results.size() == 0) begin
          report_mismatch("beat with nothing pending, sum numerator", got.sum_num, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.sum_num !== want.sum_num)
            report_mismatch("sum numerator", got.sum_num, want.sum_num);
          if (got.sum_den !== want.sum_den)
            report_mismatch("sum denominator", got.sum_den, want.sum_den);
          if (got.prod_num !== want.prod_num)
            report_mismatch("product numerator", got.prod_num, want.prod_num);
          if (got.prod_den !== want.prod_den)
            report_mismatch("product denominator", got.prod_den, want.prod_den);
          if (got.undef !== want.undef)
            report_mismatch("undefined", got.undef, want.undef);
        end
        pop_wait = recv_idle_on ? $urandom_range(0, 6) : 0;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("rational_add_mul_reduce_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n                 = 1'b0;
    in_push               = 1'b0;
    in_first_numerator    = '0;
    in_first_denominator  = '0;
    in_second_numerator   = '0;
    in_second_denominator = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_zero_denominator();
    test_zero_numerator();
    test_drain_pause();
    test_random_traffic();

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("rational_add_mul_reduce_tb: clean");
    end else begin
      $display("rational_add_mul_reduce_tb: errors");
    end
    $finish;
  end

endmodule
